FILE: rtl/core/lpfp_pkg.sv
// lpfp_pkg: shared types and constants of the length-prefixed frame parser
package lpfp_pkg;

    localparam logic [7:0]  HDR_BYTE       = 8'h55;
    localparam logic [12:0] LIMIT_CAP      = 13'd4096;
    localparam logic [7:0]  CODE_STATUS    = 8'hE3;
    localparam logic [7:0]  CODE_HANDSHAKE = 8'hC0;
    localparam int          PLAY_BIT       = 2;
    localparam logic [12:0] STATUS_IDX_E3  = 13'd2;
    localparam logic [12:0] STATUS_IDX_C0  = 13'd15;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_CODE   = 3'd3,
        PH_DATA   = 3'd4,
        PH_CHECK  = 3'd5
    } phase_t;

    typedef struct packed {
        logic        playing;
        logic        playing_known;
        logic        checksum_good;
        logic [11:0] data_length;
        logic [11:0] data_offset;
        logic [7:0]  data_byte;
        logic [7:0]  response_code;
        logic        item_kind;
    } result_t;

endpackage

FILE: rtl/core/length_prefixed_frame_parser.sv
// length_prefixed_frame_parser: top level, byte stream in, data and end-of-frame beats out
// a result beat is registered in the output stage before it appears on m_, or held in the skid entry under stall
// throughput: one input beat per cycle while s_tready is high; the frame state updates on each accepted beat
// a stalled output is absorbed by one skid entry, so s_tready drops only with two results held or in reset
// reset: synchronous active-low aresetn; hunting for header, limit = min(MAX_BODY, 4096)
module length_prefixed_frame_parser #(
    parameter int MAX_BODY = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,     // max_body_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // response_code[7:0], data_byte[15:8], data_offset[27:16], data_length[39:28],
    // checksum_good[40], playing_known[41], playing[42], zero pad[47:43]
    output logic [47:0] m_tdata,
    output logic [0:0]  m_tuser        // item_kind
);

    localparam int          LIMIT_INT   = (MAX_BODY > 4096) ? 4096 : MAX_BODY;
    localparam logic [12:0] LIMIT_RESET = LIMIT_INT[12:0];

    logic              in_accept;
    logic              res_valid;
    lpfp_pkg::result_t res;
    lpfp_pkg::result_t out_res;

    assign in_accept = s_tvalid && s_tready;

    lpfp_parser_core #(
        .LIMIT_RESET(LIMIT_RESET)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_accept(in_accept),
        .in_byte  (s_tdata),
        .res_valid(res_valid),
        .res      (res)
    );

    lpfp_out_skid u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_accept && res_valid),
        .in_data  (res),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_data (out_res),
        .out_ready(m_tready)
    );

    assign m_tuser = out_res.item_kind;
    assign m_tdata = {5'd0, out_res.playing, out_res.playing_known, out_res.checksum_good,
                      out_res.data_length, out_res.data_offset, out_res.data_byte,
                      out_res.response_code};

    // out of reset, input stalls only while a result is held on the output
    a_stall_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result held");

    a_end_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[27:8] == 20'd0))
        else $error("end beat carries data byte or offset");

    a_data_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[47:28] == 20'd0))
        else $error("data beat carries end-of-frame fields");

    a_playing_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[41]) |-> m_tdata[40])
        else $error("playback flag decoded on a bad checksum");

endmodule

FILE: rtl/core/lpfp_parser_core.sv
// lpfp_parser_core: frame state machine, length check and checksum, one beat per cycle while in_accept is high
module lpfp_parser_core #(
    parameter logic [12:0] LIMIT_RESET = 13'd4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [12:0]        cfg_wdata,
    input  logic               in_accept,
    input  logic [7:0]         in_byte,
    output logic               res_valid,
    output lpfp_pkg::result_t  res
);

    lpfp_pkg::phase_t phase_reg, phase_next;
    logic [12:0] max_len_reg;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [12:0] body_len_reg, body_len_next;
    logic [12:0] count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  code_reg, code_next;
    logic        play_reg, play_next;
    logic        seen_reg, seen_next;

    logic [12:0] lim;
    logic [15:0] len_word;
    logic        len_bad;
    logic        has_status;
    logic [12:0] status_idx;
    logic [7:0]  sum_add;
    logic        good;
    logic        known;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= lpfp_pkg::PH_HUNT;
            len_lo_reg   <= 8'd0;
            body_len_reg <= 13'd0;
            count_reg    <= 13'd0;
            sum_reg      <= 8'd0;
            code_reg     <= 8'd0;
            play_reg     <= 1'b0;
            seen_reg     <= 1'b0;
        end else if (in_accept) begin
            phase_reg    <= phase_next;
            len_lo_reg   <= len_lo_next;
            body_len_reg <= body_len_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            code_reg     <= code_next;
            play_reg     <= play_next;
            seen_reg     <= seen_next;
        end
    end

    assign lim      = (max_len_reg > lpfp_pkg::LIMIT_CAP) ? lpfp_pkg::LIMIT_CAP : max_len_reg;
    assign len_word = {in_byte, len_lo_reg};
    assign len_bad  = (len_word == 16'd0) || (len_word > {3'd0, lim});
    assign sum_add  = sum_reg + in_byte;
    assign good     = (sum_add == 8'd0);
    assign known    = good && seen_reg;

    always_comb begin
        has_status = 1'b0;
        status_idx = 13'd0;
        if (code_reg == lpfp_pkg::CODE_STATUS) begin
            has_status = 1'b1;
            status_idx = lpfp_pkg::STATUS_IDX_E3;
        end else if (code_reg == lpfp_pkg::CODE_HANDSHAKE) begin
            has_status = 1'b1;
            status_idx = lpfp_pkg::STATUS_IDX_C0;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        len_lo_next   = len_lo_reg;
        body_len_next = body_len_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        code_next     = code_reg;
        play_next     = play_reg;
        seen_next     = seen_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.response_code = code_reg;
        unique case (phase_reg)
            lpfp_pkg::PH_LEN_LO: begin
                len_lo_next = in_byte;
                phase_next  = lpfp_pkg::PH_LEN_HI;
            end
            lpfp_pkg::PH_LEN_HI: begin
                if (len_bad) begin
                    // resync on a header seen inside the length bytes
                    if (len_lo_reg == lpfp_pkg::HDR_BYTE) begin
                        len_lo_next = in_byte;
                        phase_next  = lpfp_pkg::PH_LEN_HI;
                    end else if (in_byte == lpfp_pkg::HDR_BYTE) begin
                        phase_next = lpfp_pkg::PH_LEN_LO;
                    end else begin
                        phase_next = lpfp_pkg::PH_HUNT;
                    end
                end else begin
                    body_len_next = len_word[12:0];
                    sum_next      = len_lo_reg + in_byte;
                    count_next    = 13'd0;
                    seen_next     = 1'b0;
                    play_next     = 1'b0;
                    phase_next    = lpfp_pkg::PH_CODE;
                end
            end
            lpfp_pkg::PH_CODE: begin
                code_next  = in_byte;
                sum_next   = sum_add;
                phase_next = (body_len_reg <= 13'd1) ? lpfp_pkg::PH_CHECK : lpfp_pkg::PH_DATA;
            end
            lpfp_pkg::PH_DATA: begin
                if (has_status && (count_reg == status_idx)) begin
                    play_next = in_byte[lpfp_pkg::PLAY_BIT];
                    seen_next = 1'b1;
                end
                sum_next          = sum_add;
                count_next        = count_reg + 13'd1;
                res_valid         = 1'b1;
                res.item_kind     = 1'b0;
                res.data_byte     = in_byte;
                res.data_offset   = count_reg[11:0];
                if (({1'b0, count_reg} + 14'd2) >= {1'b0, body_len_reg}) begin
                    phase_next = lpfp_pkg::PH_CHECK;
                end
            end
            lpfp_pkg::PH_CHECK: begin
                sum_next          = sum_add;
                res_valid         = 1'b1;
                res.item_kind     = 1'b1;
                res.data_length   = body_len_reg[11:0] - 12'd1;
                res.checksum_good = good;
                res.playing_known = known;
                res.playing       = known && play_reg;
                phase_next        = lpfp_pkg::PH_HUNT;
            end
            default: begin
                phase_next = (in_byte == lpfp_pkg::HDR_BYTE) ? lpfp_pkg::PH_LEN_LO
                                                              : lpfp_pkg::PH_HUNT;
            end
        endcase
    end

endmodule

FILE: rtl/core/lpfp_out_skid.sv
// lpfp_out_skid: result register with one skid stage so input keeps flowing for one more result under stall
module lpfp_out_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  lpfp_pkg::result_t  in_data,
    output logic               in_ready,
    output logic               out_valid,
    output lpfp_pkg::result_t  out_data,
    input  logic               out_ready
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    lpfp_pkg::result_t out_data_reg;
    lpfp_pkg::result_t skid_data_reg;

    // no beat is taken while reset is held
    assign in_ready  = aresetn && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

FILE: tb/length_prefixed_frame_parser_test.sv
// length_prefixed_frame_parser_test: self-checking bench, directed byte table then random frames
`timescale 1ns / 100ps

module length_prefixed_frame_parser_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 340;
    localparam int NUM_PHASES = 5;

    typedef enum bit {ROW_BYTE, ROW_LIMIT} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [12:0]        value;
        bit                 typed;
        lpfp_pkg::result_t  want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    // frame tracker state, mirrors the parser
    lpfp_pkg::phase_t fp_phase = lpfp_pkg::PH_HUNT;
    logic [7:0]  fp_len_lo = '0;
    logic [12:0] fp_body = '0;
    logic [12:0] fp_count = '0;
    logic [7:0]  fp_sum = '0;
    logic [7:0]  fp_code = '0;
    logic [7:0]  fp_status = '0;
    logic        fp_status_seen = 1'b0;
    logic [12:0] fp_limit = lpfp_pkg::LIMIT_CAP;

    lpfp_pkg::result_t pending[$];
    row_t    script [24];
    int      body_cap = 4096;
    int      src_idle_pct = 0;
    int      sink_stall_pct = 0;
    int      items_done = 0;
    int      check_errors = 0;
    int      idle_cycles = 0;

    length_prefixed_frame_parser uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic string describe(input lpfp_pkg::result_t r);
        return $sformatf("kind=%0d code=%02h byte=%02h off=%0d len=%0d good=%0d known=%0d play=%0d",
                         r.item_kind, r.response_code, r.data_byte, r.data_offset,
                         r.data_length, r.checksum_good, r.playing_known, r.playing);
    endfunction

    function automatic row_t pass_byte(input logic [7:0] b);
        row_t row;
        row.kind = ROW_BYTE;
        row.value = {5'b0, b};
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic row_t end_byte(input logic [7:0] b, input logic [7:0] code,
                                      input logic [11:0] len, input logic good,
                                      input logic known, input logic play);
        row_t row;
        row = pass_byte(b);
        row.typed = 1'b1;
        row.want.item_kind = 1'b1;
        row.want.response_code = code;
        row.want.data_length = len;
        row.want.checksum_good = good;
        row.want.playing_known = known;
        row.want.playing = play;
        return row;
    endfunction

    function automatic row_t new_limit(input logic [12:0] v);
        row_t row;
        row = pass_byte('0);
        row.kind = ROW_LIMIT;
        row.value = v;
        return row;
    endfunction

    // advance the frame tracker by one byte, report the beat it should produce
    task automatic parse_byte(input logic [7:0] b, output bit emits,
                              output lpfp_pkg::result_t r);
        logic [15:0] len;
        logic [12:0] lim;
        logic [12:0] body_m1;
        lim = (fp_limit > lpfp_pkg::LIMIT_CAP) ? lpfp_pkg::LIMIT_CAP : fp_limit;
        emits = 1'b0;
        r = '0;
        case (fp_phase)
            lpfp_pkg::PH_LEN_LO: begin
                fp_len_lo = b;
                fp_phase = lpfp_pkg::PH_LEN_HI;
            end
            lpfp_pkg::PH_LEN_HI: begin
                len = {b, fp_len_lo};
                if (len == 16'd0 || len > {3'b0, lim}) begin
                    // resync on a header byte buried in the length field
                    if (fp_len_lo == lpfp_pkg::HDR_BYTE) begin
                        fp_len_lo = b;
                    end else if (b == lpfp_pkg::HDR_BYTE) begin
                        fp_phase = lpfp_pkg::PH_LEN_LO;
                    end else begin
                        fp_phase = lpfp_pkg::PH_HUNT;
                    end
                end else begin
                    fp_body = len[12:0];
                    fp_sum = fp_len_lo + b;
                    fp_count = '0;
                    fp_status_seen = 1'b0;
                    fp_status = '0;
                    fp_phase = lpfp_pkg::PH_CODE;
                end
            end
            lpfp_pkg::PH_CODE: begin
                fp_code = b;
                fp_sum = fp_sum + b;
                fp_phase = (fp_body <= 13'd1) ? lpfp_pkg::PH_CHECK : lpfp_pkg::PH_DATA;
            end
            lpfp_pkg::PH_DATA: begin
                if ((fp_code == lpfp_pkg::CODE_STATUS && fp_count == lpfp_pkg::STATUS_IDX_E3) ||
                    (fp_code == lpfp_pkg::CODE_HANDSHAKE &&
                     fp_count == lpfp_pkg::STATUS_IDX_C0)) begin
                    fp_status = b;
                    fp_status_seen = 1'b1;
                end
                fp_sum = fp_sum + b;
                emits = 1'b1;
                r.item_kind = 1'b0;
                r.response_code = fp_code;
                r.data_byte = b;
                r.data_offset = fp_count[11:0];
                fp_count = fp_count + 13'd1;
                if (fp_count + 13'd1 >= fp_body) fp_phase = lpfp_pkg::PH_CHECK;
            end
            lpfp_pkg::PH_CHECK: begin
                fp_sum = fp_sum + b;
                body_m1 = fp_body - 13'd1;
                emits = 1'b1;
                r.item_kind = 1'b1;
                r.response_code = fp_code;
                r.data_length = body_m1[11:0];
                r.checksum_good = (fp_sum == 8'd0);
                r.playing_known = r.checksum_good && fp_status_seen;
                r.playing = r.playing_known && fp_status[lpfp_pkg::PLAY_BIT];
                fp_phase = lpfp_pkg::PH_HUNT;
            end
            default: begin
                fp_phase = (b == lpfp_pkg::HDR_BYTE) ? lpfp_pkg::PH_LEN_LO : lpfp_pkg::PH_HUNT;
            end
        endcase
    endtask

    // present one beat, return at the edge that takes it; tvalid stays high
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while (int'($urandom_range(99)) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic feed(input logic [7:0] b);
        bit                emits;
        lpfp_pkg::result_t r;
        if (fp_phase != lpfp_pkg::PH_HUNT || b == lpfp_pkg::HDR_BYTE) items_done++;
        send_byte(b);
        parse_byte(b, emits, r);
        if (emits) pending.push_back(r);
    endtask

    task automatic write_limit(input logic [12:0] v);
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        // a byte that makes no beat may still be inside the parser
        repeat (4) @(posedge aclk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        fp_limit = v;
        body_cap = (v > lpfp_pkg::LIMIT_CAP) ? 4096 : int'(v);
    endtask

    // header, length, and when the length is acceptable the code, data and checksum
    task automatic send_frame(input int body, input logic [7:0] code, input bit sum_ok);
        logic [7:0] total;
        logic [7:0] b;
        feed(lpfp_pkg::HDR_BYTE);
        feed(body[7:0]);
        feed(body[15:8]);
        if (body == 0 || body > body_cap) return;
        total = body[7:0] + body[15:8];
        feed(code);
        total = total + code;
        for (int k = 1; k < body; k++) begin
            b = 8'($urandom_range(255));
            total = total + b;
            feed(b);
        end
        b = 8'd0 - total;
        if (!sum_ok) b = b + 8'($urandom_range(1, 255));
        feed(b);
    endtask

    task automatic random_burst();
        int         pick;
        int         body;
        int         span;
        logic [7:0] code;
        pick = $urandom_range(99);
        if (pick < 12) begin
            // line noise between frames, now and then a stray header
            repeat ($urandom_range(1, 4)) feed(8'($urandom_range(255)));
            return;
        end
        pick = $urandom_range(99);
        code = (pick < 40) ? lpfp_pkg::CODE_STATUS :
               (pick < 70) ? lpfp_pkg::CODE_HANDSHAKE : 8'($urandom_range(255));
        // handshake frames need sixteen data bytes to reach their status byte
        span = (code == lpfp_pkg::CODE_HANDSHAKE) ? 40 : 24;
        if (span > body_cap) span = body_cap;
        pick = $urandom_range(99);
        if (pick < 6) begin
            body = 0;
        end else if (pick < 12) begin
            body = body_cap + 1 + int'($urandom_range(3));
        end else if (pick < 16) begin
            body = int'($urandom_range(255)) * 256 + int'(lpfp_pkg::HDR_BYTE);
        end else if (pick < 20) begin
            body = int'($urandom_range(65535));
        end else if (pick < 25 && body_cap <= 64) begin
            body = body_cap;
        end else begin
            body = int'($urandom_range(1, span));
        end
        send_frame(body, code, int'($urandom_range(99)) < 85);
    endtask

    always @(posedge aclk) begin
        lpfp_pkg::result_t got;
        lpfp_pkg::result_t want;
        m_tready <= int'($urandom_range(99)) >= sink_stall_pct;
        if (aresetn && m_tvalid && m_tready) begin
            got.item_kind = m_tuser[0];
            got.response_code = m_tdata[7:0];
            got.data_byte = m_tdata[15:8];
            got.data_offset = m_tdata[27:16];
            got.data_length = m_tdata[39:28];
            got.checksum_good = m_tdata[40];
            got.playing_known = m_tdata[41];
            got.playing = m_tdata[42];
            if (pending.size() == 0) begin
                check_errors++;
                $display("%0t: unexpected result beat, expected none, got %s",
                         $time, describe(got));
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    check_errors++;
                    $display("%0t: result beat differs, expected %s, got %s",
                             $time, describe(want), describe(got));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        bit                emits;
        lpfp_pkg::result_t r;
        script = '{
            pass_byte(lpfp_pkg::HDR_BYTE), pass_byte(8'h04), pass_byte(8'h00),
            pass_byte(lpfp_pkg::CODE_STATUS),
            pass_byte(8'h00), pass_byte(8'hFF), pass_byte(8'h04),
            end_byte(8'h16, lpfp_pkg::CODE_STATUS, 12'd3, 1'b1, 1'b1, 1'b1),
            // low length byte is a header, then the high one, then a zero length
            pass_byte(lpfp_pkg::HDR_BYTE), pass_byte(lpfp_pkg::HDR_BYTE), pass_byte(8'h20),
            pass_byte(lpfp_pkg::HDR_BYTE),
            pass_byte(8'h00), pass_byte(8'h00),
            // zero limit turns away even a one-byte body
            new_limit(13'd0), pass_byte(lpfp_pkg::HDR_BYTE), pass_byte(8'h01), pass_byte(8'h00),
            // limit above the cap, code-only frame with a bad sum
            new_limit(13'h1FFF), pass_byte(lpfp_pkg::HDR_BYTE), pass_byte(8'h01),
            pass_byte(8'h00),
            pass_byte(lpfp_pkg::CODE_HANDSHAKE),
            end_byte(8'hFF, lpfp_pkg::CODE_HANDSHAKE, 12'd0, 1'b0, 1'b0, 1'b0)
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_LIMIT) begin
                write_limit(script[i].value);
            end else if (script[i].typed) begin
                send_byte(script[i].value[7:0]);
                parse_byte(script[i].value[7:0], emits, r);
                pending.push_back(script[i].want);
            end else begin
                feed(script[i].value[7:0]);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    write_limit(lpfp_pkg::LIMIT_CAP);
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    write_limit(13'h1FFF);
                    src_idle_pct = 66;
                    sink_stall_pct = 0;
                end
                2: begin
                    write_limit(13'd1);
                    src_idle_pct = 0;
                    sink_stall_pct = 66;
                end
                3: begin
                    write_limit(13'($urandom_range(2, 64)));
                    src_idle_pct = 31;
                    sink_stall_pct = 31;
                end
                default: begin
                    write_limit(13'($urandom_range(17, 300)));
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            items_done = 0;
            while (items_done < ITEMS_PER_PHASE) random_burst();
        end

        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (check_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
